[hdl/real_spherical_harmonic_poly_macros.svh]
`ifndef REAL_SPHERICAL_HARMONIC_POLY_MACROS_SVH
`define REAL_SPHERICAL_HARMONIC_POLY_MACROS_SVH

// same-cycle implication
`define RSHP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define RSHP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rshp_pkg.sv]
package rshp_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COMP_W    = 16;
  localparam int DEG_W     = 3;
  localparam int ORD_W     = 4;
  localparam int VAL_W     = 19;
  localparam int MAX_DEG   = 4;

  // degree-2 products of components
  localparam int SQ_W    = 2 * COMP_W;
  // first factor: up to 35*z^2 less a constant
  localparam int OPA_W   = SQ_W + 6;
  // second factor: up to x^2-y^2+2xy
  localparam int OPB_W   = SQ_W + 2;
  localparam int PROD_W  = OPA_W + OPB_W;
  // first factor is multiplied in two halves
  localparam int SPLIT_W = OPA_W / 2;
  localparam int HI_W    = OPA_W - SPLIT_W;
  localparam int PLO_W   = SPLIT_W + 1 + OPB_W;
  localparam int PHI_W   = HI_W + OPB_W;

  // rounding shift, in units of FRAC_BITS
  typedef enum logic [1:0] {
    RND_NONE,
    RND_ONE,
    RND_TWO,
    RND_THREE
  } rnd_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [DEG_W-1:0]        degree;
    logic signed [ORD_W-1:0] order;
  } sel_t;

  typedef struct packed {
    logic signed [SQ_W-1:0] xx;
    logic signed [SQ_W-1:0] yy;
    logic signed [SQ_W-1:0] zz;
    logic signed [SQ_W-1:0] xy;
    logic signed [SQ_W-1:0] yz;
    logic signed [SQ_W-1:0] xz;
  } quad_t;

  typedef struct packed {
    logic signed [OPA_W-1:0] opa;
    logic signed [OPB_W-1:0] opb;
    rnd_t                    rnd;
    logic                    cnst;   // add 3 at degree-four scale
  } term_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] acc;
    rnd_t                     rnd;
  } sum_t;

endpackage

[hdl/real_spherical_harmonic_poly.sv]
// Unnormalised real spherical-harmonic polynomials, degree 0 to 4, order -l..l.
// One beat per cycle in, one per cycle out while out_ready is high, through the
// product, operand-forming, split-multiply, sum and round/saturate stages.
// Each form is evaluated as one product of two selected factors built from
// the component squares and cross products, plus a constant for l=4 m=0, held
// exactly, then rounded to nearest (ties up) at 14 fraction bits and saturated
// to 19 bits. Degree above four, or an order outside -l..l for degree two to
// four, gives 0; degree one with an order other than -1 or 0 gives x. Each stage
// holds its beat under back-pressure and fills bubbles, so input keeps flowing
// while out_ready is low until all five stages are full.
`include "real_spherical_harmonic_poly_macros.svh"

module real_spherical_harmonic_poly
  import rshp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COMP_W-1:0] x_comp,
  input  logic signed [COMP_W-1:0] y_comp,
  input  logic signed [COMP_W-1:0] z_comp,
  input  logic [DEG_W-1:0]         degree,
  input  logic signed [ORD_W-1:0]  order,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  value
);

  localparam int NSTAGE = 5;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] vld_in;
  logic [NSTAGE-1:0] en;
  logic              in_acc;
  logic              out_acc;
  vec_t              vec;
  quad_t             quad;
  sel_t              sel;
  term_t             term;
  sum_t              sum;

  // a stage loads when empty or when its beat moves on
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in    = {vld[NSTAGE-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  rshp_square u_square (
    .clk    (clk),
    .en     (en[0]),
    .x_comp (x_comp),
    .y_comp (y_comp),
    .z_comp (z_comp),
    .degree (degree),
    .order  (order),
    .vec    (vec),
    .quad   (quad),
    .sel    (sel)
  );

  rshp_form u_form (
    .clk  (clk),
    .en   (en[1]),
    .vec  (vec),
    .quad (quad),
    .sel  (sel),
    .term (term)
  );

  rshp_mult u_mult (
    .clk  (clk),
    .en   (en[3:2]),
    .term (term),
    .sum  (sum)
  );

  rshp_round u_round (
    .clk   (clk),
    .en    (en[4]),
    .sum   (sum),
    .value (value)
  );

  `RSHP_ASSERT_NXT(a_beat_count, clk, rst, 1'b1, $countones(vld) == $past($countones(vld)) + $past(int'(in_acc)) - $past(int'(out_acc)), "beat lost or duplicated in pipeline")
  `RSHP_ASSERT_IMP(a_full_stall, clk, rst, &vld && !out_ready, !in_ready, "input taken while pipeline full and stalled")

endmodule

[hdl/rshp_square.sv]
module rshp_square
  import rshp_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COMP_W-1:0] x_comp,
  input  logic signed [COMP_W-1:0] y_comp,
  input  logic signed [COMP_W-1:0] z_comp,
  input  logic [DEG_W-1:0]         degree,
  input  logic signed [ORD_W-1:0]  order,
  output vec_t                     vec,
  output quad_t                    quad,
  output sel_t                     sel
);

  logic signed [SQ_W-1:0] xx_next, yy_next, zz_next, xy_next, yz_next, xz_next;

  assign xx_next = x_comp * x_comp;
  assign yy_next = y_comp * y_comp;
  assign zz_next = z_comp * z_comp;
  assign xy_next = x_comp * y_comp;
  assign yz_next = y_comp * z_comp;
  assign xz_next = x_comp * z_comp;

  always_ff @(posedge clk) begin
    if (en) begin
      vec.x      <= x_comp;
      vec.y      <= y_comp;
      vec.z      <= z_comp;
      quad.xx    <= xx_next;
      quad.yy    <= yy_next;
      quad.zz    <= zz_next;
      quad.xy    <= xy_next;
      quad.yz    <= yz_next;
      quad.xz    <= xz_next;
      sel.degree <= degree;
      sel.order  <= order;
    end
  end

endmodule

[hdl/rshp_form.sv]
`include "real_spherical_harmonic_poly_macros.svh"

module rshp_form
  import rshp_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  vec_t  vec,
  input  quad_t quad,
  input  sel_t  sel,
  output term_t term
);

  localparam logic signed [OPA_W-1:0] ONE_F     = OPA_W'(1) <<< FRAC_BITS;
  localparam logic signed [OPA_W-1:0] ONE_2F    = OPA_W'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [OPA_W-1:0] THREE_2F  = OPA_W'(3) <<< (2 * FRAC_BITS);
  localparam logic signed [OPA_W-1:0] THIRTY_2F = OPA_W'(30) <<< (2 * FRAC_BITS);
  localparam logic signed [OPB_W-1:0] OPB_ONE   = OPB_W'(1);

  logic signed [OPA_W-1:0] ax, ay, az, xx, yy, zz, xy, yz, xz;
  logic signed [OPA_W-1:0] d_xy, d_x3y, d_3xy, z3_1, z5_1, z5_3, z7_1, z7_3, z35;
  logic signed [OPA_W-1:0] q_lo, q_hi;
  logic signed [OPB_W-1:0] bx, by, bz, bxy, byz, bxz, bzz, bdxy, bqh;
  term_t                   term_next;

  assign ax = OPA_W'($signed(vec.x));
  assign ay = OPA_W'($signed(vec.y));
  assign az = OPA_W'($signed(vec.z));
  assign xx = OPA_W'($signed(quad.xx));
  assign yy = OPA_W'($signed(quad.yy));
  assign zz = OPA_W'($signed(quad.zz));
  assign xy = OPA_W'($signed(quad.xy));
  assign yz = OPA_W'($signed(quad.yz));
  assign xz = OPA_W'($signed(quad.xz));

  // lower-order terms carry 2^(2F) so everything sits at one scale
  assign d_xy  = xx - yy;
  assign d_x3y = xx - 3 * yy;
  assign d_3xy = 3 * xx - yy;
  assign z3_1  = 3 * zz - ONE_2F;
  assign z5_1  = 5 * zz - ONE_2F;
  assign z5_3  = 5 * zz - THREE_2F;
  assign z7_1  = 7 * zz - ONE_2F;
  assign z7_3  = 7 * zz - THREE_2F;
  assign z35   = 35 * zz - THIRTY_2F;
  // x^4-6x^2y^2+y^4 = (x^2-y^2-2xy)(x^2-y^2+2xy)
  assign q_lo  = d_xy - (xy <<< 1);
  assign q_hi  = d_xy + (xy <<< 1);

  assign bx   = OPB_W'($signed(vec.x));
  assign by   = OPB_W'($signed(vec.y));
  assign bz   = OPB_W'($signed(vec.z));
  assign bxy  = OPB_W'($signed(quad.xy));
  assign byz  = OPB_W'($signed(quad.yz));
  assign bxz  = OPB_W'($signed(quad.xz));
  assign bzz  = OPB_W'($signed(quad.zz));
  assign bdxy = OPB_W'(d_xy);
  assign bqh  = OPB_W'(q_hi);

  always_comb begin
    term_next.opa  = '0;
    term_next.opb  = '0;
    term_next.rnd  = RND_NONE;
    term_next.cnst = 1'b0;
    unique case (sel.degree)
      3'd0: begin
        term_next.opa = ONE_F;
        term_next.opb = OPB_ONE;
      end
      3'd1: begin
        term_next.opb = OPB_ONE;
        unique case (sel.order)
          -4'sd1:  term_next.opa = ay;
          4'sd0:   term_next.opa = az;
          default: term_next.opa = ax;
        endcase
      end
      3'd2: begin
        term_next.rnd = RND_ONE;
        term_next.opb = OPB_ONE;
        unique case (sel.order)
          -4'sd2:  term_next.opa = xy;
          -4'sd1:  term_next.opa = yz;
          4'sd0:   term_next.opa = z3_1;
          4'sd1:   term_next.opa = xz;
          4'sd2:   term_next.opa = d_xy;
          default: term_next.opb = '0;
        endcase
      end
      3'd3: begin
        term_next.rnd = RND_TWO;
        unique case (sel.order)
          -4'sd3: begin term_next.opa = d_3xy; term_next.opb = by; end
          -4'sd2: begin term_next.opa = xy;    term_next.opb = bz; end
          -4'sd1: begin term_next.opa = z5_1;  term_next.opb = by; end
          4'sd0:  begin term_next.opa = z5_3;  term_next.opb = bz; end
          4'sd1:  begin term_next.opa = z5_1;  term_next.opb = bx; end
          4'sd2:  begin term_next.opa = d_xy;  term_next.opb = bz; end
          4'sd3:  begin term_next.opa = d_x3y; term_next.opb = bx; end
          default: ;
        endcase
      end
      3'd4: begin
        term_next.rnd = RND_THREE;
        unique case (sel.order)
          -4'sd4: begin term_next.opa = d_xy;  term_next.opb = bxy;  end
          -4'sd3: begin term_next.opa = d_3xy; term_next.opb = byz;  end
          -4'sd2: begin term_next.opa = z7_1;  term_next.opb = bxy;  end
          -4'sd1: begin term_next.opa = z7_3;  term_next.opb = byz;  end
          4'sd0: begin
            term_next.opa  = z35;
            term_next.opb  = bzz;
            term_next.cnst = 1'b1;
          end
          4'sd1:  begin term_next.opa = z7_3;  term_next.opb = bxz;  end
          4'sd2:  begin term_next.opa = z7_1;  term_next.opb = bdxy; end
          4'sd3:  begin term_next.opa = d_x3y; term_next.opb = bxz;  end
          4'sd4:  begin term_next.opa = q_lo;  term_next.opb = bqh;  end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term <= term_next;
    end
  end

  `RSHP_ASSERT_NXT(a_high_degree_zero, clk, 1'b0, en && sel.degree > DEG_W'(MAX_DEG), term.opa == '0 && !term.cnst, "degree above four produced a term")

endmodule

[hdl/rshp_mult.sv]
module rshp_mult
  import rshp_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] en,     // [0] partial products, [1] sum
  input  term_t      term,
  output sum_t       sum
);

  localparam logic signed [PROD_W-1:0] RB_ONE   = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] RB_TWO   = PROD_W'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] RB_THREE = PROD_W'(1) <<< (3 * FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] THREE_4F = PROD_W'(3) <<< (4 * FRAC_BITS);

  typedef struct packed {
    logic signed [PLO_W-1:0] plo;
    logic signed [PHI_W-1:0] phi;
    rnd_t                    rnd;
    logic                    cnst;
  } part_t;

  part_t                    part;
  logic signed [PROD_W-1:0] bias;

  // half-ulp for rounding, plus the constant of the l=4 m=0 form
  always_comb begin
    unique case (part.rnd)
      RND_NONE:  bias = '0;
      RND_ONE:   bias = RB_ONE;
      RND_TWO:   bias = RB_TWO;
      RND_THREE: bias = RB_THREE;
    endcase
    if (part.cnst) begin
      bias = bias + THREE_4F;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      part.plo  <= $signed({1'b0, term.opa[SPLIT_W-1:0]}) * $signed(term.opb);
      part.phi  <= $signed(term.opa[OPA_W-1:SPLIT_W]) * $signed(term.opb);
      part.rnd  <= term.rnd;
      part.cnst <= term.cnst;
    end
    if (en[1]) begin
      sum.acc <= (PROD_W'($signed(part.phi)) <<< SPLIT_W)
                 + PROD_W'($signed(part.plo)) + bias;
      sum.rnd <= part.rnd;
    end
  end

endmodule

[hdl/rshp_round.sv]
`include "real_spherical_harmonic_poly_macros.svh"

module rshp_round
  import rshp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  sum_t                    sum,
  output logic signed [VAL_W-1:0] value
);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

  logic signed [PROD_W-1:0] sh;
  logic [PROD_W-VAL_W:0]    top_bits;
  logic signed [VAL_W-1:0]  value_next;

  always_comb begin
    unique case (sum.rnd)
      RND_NONE:  sh = sum.acc;
      RND_ONE:   sh = $signed(sum.acc) >>> FRAC_BITS;
      RND_TWO:   sh = $signed(sum.acc) >>> (2 * FRAC_BITS);
      RND_THREE: sh = $signed(sum.acc) >>> (3 * FRAC_BITS);
    endcase
    // fits when everything above the sign bit copies it
    top_bits = sh[PROD_W-1:VAL_W-1];
    if (&top_bits || !(|top_bits)) begin
      value_next = sh[VAL_W-1:0];
    end else if (sh[PROD_W-1]) begin
      value_next = VAL_MIN;
    end else begin
      value_next = VAL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

  `RSHP_ASSERT_NXT(a_sign_kept, clk, 1'b0, en && !sum.acc[PROD_W-1], !value[VAL_W-1], "non-negative sum gave a negative value")

endmodule
